// File: hw/rtl/cwt_pkg.sv
// ---------------------------------------------------------------------------
// CRTC write trap package
// Port codes, register masks, trap constants and the transfer types shared
// by the trap core and the top level.
// ---------------------------------------------------------------------------
package cwt_pkg;

    // Default number of implemented CRTC registers
    localparam int CRTC_REG_COUNT_DEF = 32;

    // Field widths
    localparam int PORT_W = 4;
    localparam int BYTE_W = 8;
    localparam int IDX_W  = 5;

    // Stream packing widths (tdata filled to whole bytes)
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 16;

    // Access kinds
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Port offsets inside the window
    localparam logic [PORT_W-1:0] PORT_INDEX   = 4'd4;
    localparam logic [PORT_W-1:0] PORT_DATA    = 4'd5;
    localparam logic [PORT_W-1:0] PORT_MODE    = 4'd8;
    localparam logic [PORT_W-1:0] PORT_STATUS  = 4'd13;
    localparam logic [PORT_W-1:0] PORT_CONTROL = 4'd14;
    localparam logic [PORT_W-1:0] PORT_LATCH   = 4'd15;

    // Trap control and status bits
    localparam int CTRL_TRAP_OFF_BIT = 6;    // 0x40: trapping disabled
    localparam int CTRL_NMI_EN_BIT   = 7;    // 0x80: NMI enable
    localparam logic [BYTE_W-1:0] STATUS_TRAP_FLAG = 8'h20;
    localparam logic [BYTE_W-1:0] STATUS_MODE_FLAG = 8'h80;
    localparam logic [BYTE_W-1:0] STATUS_CTRL_INIT = 8'h1f;
    localparam logic [BYTE_W-1:0] STATUS_NMI_FLAG  = 8'h40;
    localparam logic [BYTE_W-1:0] STATUS_KEEP_MASK = 8'h1f;
    localparam logic [BYTE_W-1:0] CTRL_READ_MASK   = 8'hc7;
    localparam logic [BYTE_W-1:0] CTRL_READ_SET    = 8'h10;
    localparam logic [BYTE_W-1:0] UNCLAIMED_DATA   = 8'hff;
    localparam logic [IDX_W-1:0]  TRAP_MAX_INDEX   = 5'd11;

    // Writable bits of each CRTC register
    localparam logic [BYTE_W-1:0] REG_MASK [32] = '{
        8'hff, 8'hff, 8'hff, 8'hff, 8'h7f, 8'h1f, 8'h7f, 8'h7f,
        8'hf3, 8'h1f, 8'h7f, 8'h1f, 8'h3f, 8'hff, 8'h3f, 8'hff,
        8'hff, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    // One bus access
    typedef struct packed {
        logic              op;
        logic [PORT_W-1:0] port;
        logic [BYTE_W-1:0] data;
    } t_item;

    // One access result
    typedef struct packed {
        logic [BYTE_W-1:0] read_data;
        logic              claimed;
        logic              nmi_request;
    } t_result;

endpackage

// File: hw/rtl/cwt_core.sv
// ---------------------------------------------------------------------------
// CRTC write trap core
// Holds the CRTC index, register file, mode and trap registers; serves one
// access per cycle and updates the state when the access is taken.
// ---------------------------------------------------------------------------
module cwt_core #(
    parameter int CRTC_REG_COUNT = cwt_pkg::CRTC_REG_COUNT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  cwt_pkg::t_item    i_item,
    output cwt_pkg::t_result  o_result
);
    import cwt_pkg::*;

    localparam int AW = $clog2(CRTC_REG_COUNT);
    localparam logic [IDX_W:0] REG_COUNT_W = (IDX_W+1)'(CRTC_REG_COUNT);

    logic [IDX_W-1:0]  r_crtc_index, n_crtc_index;
    logic [BYTE_W-1:0] r_crtc_file [CRTC_REG_COUNT];
    logic [BYTE_W-1:0] r_mode_reg, n_mode_reg;
    logic [BYTE_W-1:0] r_trap_status, n_trap_status;
    logic [BYTE_W-1:0] r_trap_control, n_trap_control;
    logic [BYTE_W-1:0] r_trapped_data, n_trapped_data;
    logic              r_nmi_line, n_nmi_line;

    logic              idx_in_file;
    logic [BYTE_W-1:0] idx_mask;
    logic [BYTE_W-1:0] file_rd;
    logic              trap_hit;
    logic              file_we;
    logic [BYTE_W-1:0] rd;
    logic              claimed;

    // Look up the indexed register; entries beyond the file read as zero
    assign idx_in_file = ({1'b0, r_crtc_index} < REG_COUNT_W);
    assign idx_mask    = idx_in_file ? REG_MASK[r_crtc_index] : '0;
    assign file_rd     = idx_in_file ? r_crtc_file[r_crtc_index[AW-1:0]] : '0;

    // Trap a data write to the low registers while trapping is on
    assign trap_hit = !r_trap_control[CTRL_TRAP_OFF_BIT] && (r_crtc_index <= TRAP_MAX_INDEX);

    // Decode the access and form the next state
    always_comb begin
        n_crtc_index   = r_crtc_index;
        n_mode_reg     = r_mode_reg;
        n_trap_status  = r_trap_status;
        n_trap_control = r_trap_control;
        n_trapped_data = r_trapped_data;
        n_nmi_line     = r_nmi_line;
        file_we        = 1'b0;
        rd             = UNCLAIMED_DATA;
        claimed        = 1'b1;
        if (i_item.op == OP_WRITE) begin
            unique case (i_item.port)
                PORT_INDEX: begin
                    n_crtc_index = i_item.data[IDX_W-1:0];
                end
                PORT_DATA: begin
                    if (trap_hit) begin
                        if (r_trap_control[CTRL_NMI_EN_BIT]) begin
                            n_nmi_line = 1'b1;
                        end
                        n_trap_status  = STATUS_TRAP_FLAG | BYTE_W'(r_crtc_index);
                        n_trapped_data = i_item.data;
                    end else begin
                        file_we = idx_in_file;
                    end
                end
                PORT_MODE: begin
                    n_mode_reg    = i_item.data;
                    n_trap_status = r_trap_status | STATUS_MODE_FLAG;
                    if (r_trap_control[CTRL_NMI_EN_BIT]) begin
                        n_nmi_line = 1'b1;
                    end
                end
                PORT_CONTROL: begin
                    n_trap_control = i_item.data;
                    n_trap_status  = i_item.data[CTRL_NMI_EN_BIT] ?
                                     (STATUS_CTRL_INIT | STATUS_NMI_FLAG) : STATUS_CTRL_INIT;
                end
                default: begin
                    claimed = 1'b0;
                end
            endcase
        end else begin
            unique case (i_item.port)
                PORT_INDEX: begin
                    rd = BYTE_W'(r_crtc_index);
                end
                PORT_DATA: begin
                    rd = file_rd;
                end
                PORT_MODE: begin
                    rd = r_mode_reg;
                end
                PORT_STATUS: begin
                    rd            = r_trap_status;
                    n_trap_status = r_trap_status & STATUS_KEEP_MASK;
                    n_nmi_line    = 1'b0;
                end
                PORT_CONTROL: begin
                    rd = (r_trap_control & CTRL_READ_MASK) | CTRL_READ_SET;
                end
                PORT_LATCH: begin
                    rd = r_trapped_data;
                end
                default: begin
                    claimed = 1'b0;
                end
            endcase
        end
    end

    assign o_result.read_data   = rd;
    assign o_result.claimed     = claimed;
    assign o_result.nmi_request = n_nmi_line;

    // Advance the control and trap registers on each taken access
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crtc_index   <= '0;
            r_mode_reg     <= '0;
            r_trap_status  <= '0;
            r_trap_control <= '0;
            r_trapped_data <= '0;
            r_nmi_line     <= 1'b0;
        end else if (i_fire) begin
            r_crtc_index   <= n_crtc_index;
            r_mode_reg     <= n_mode_reg;
            r_trap_status  <= n_trap_status;
            r_trap_control <= n_trap_control;
            r_trapped_data <= n_trapped_data;
            r_nmi_line     <= n_nmi_line;
        end
    end

    // Clear the register file on reset, store masked data on untrapped writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CRTC_REG_COUNT; i++) begin
                r_crtc_file[i] <= '0;
            end
        end else if (i_fire && file_we) begin
            r_crtc_file[r_crtc_index[AW-1:0]] <= i_item.data & idx_mask;
        end
    end

    // A status read always drops the NMI
    a_status_read_clears_nmi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_item.op == OP_READ && i_item.port == PORT_STATUS |=> !r_nmi_line)
        else $error("NMI still high after status read");

    // The NMI only rises while NMI enable was set
    a_nmi_needs_enable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_nmi_line) |-> $past(r_trap_control[CTRL_NMI_EN_BIT]))
        else $error("NMI raised with NMI enable clear");

    // A control write leaves the low status bits set
    a_ctrl_write_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_item.op == OP_WRITE && i_item.port == PORT_CONTROL
        |=> r_trap_status[IDX_W-1:0] == STATUS_CTRL_INIT[IDX_W-1:0])
        else $error("status low bits wrong after control write");

    // An index write takes the low five data bits
    a_index_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_item.op == OP_WRITE && i_item.port == PORT_INDEX
        |=> r_crtc_index == $past(i_item.data[IDX_W-1:0]))
        else $error("CRTC index not loaded");

endmodule

// File: hw/rtl/crtc_write_trap_with_nmi.sv
// ---------------------------------------------------------------------------
// CRTC write trap with NMI
// Serves bus accesses to a 16-port CRTC register window, traps CRTC data
// writes and mode writes, and drives a trap NMI level.
// ---------------------------------------------------------------------------
// The block takes one access per clock while the result side keeps up and
// returns one result per access: an input register holds the access, the
// trap core decodes it against the current state and updates that state as
// the access moves on, and a result register holds the answer until it is
// taken. Accesses are served strictly in order, so back-to-back reads and
// writes see each other's effects as on the real bus. The result register
// and the input register stall together when the result side holds off.
module crtc_write_trap_with_nmi #(
    parameter int CRTC_REG_COUNT = cwt_pkg::CRTC_REG_COUNT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [cwt_pkg::S_TDATA_W-1:0]  i_s_tdata,  // port_offset[3:0], write_data[11:4]
    input  logic                           i_s_tuser,  // operation
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [cwt_pkg::M_TDATA_W-1:0]  o_m_tdata,  // read_data[7:0], nmi_request[8]
    output logic                           o_m_tuser   // claimed
);
    import cwt_pkg::*;

    logic    r_in_valid;
    t_item   r_in_item;
    logic    r_out_valid;
    t_result r_out_res;
    t_result core_res;
    logic    out_free;
    logic    advance;

    // Move the held access forward when the result register can take it
    assign out_free   = !r_out_valid || i_m_tready;
    assign advance    = r_in_valid && out_free;
    assign o_s_tready = !r_in_valid || advance;

    // Hold the accepted access
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_item.op   <= i_s_tuser;
            r_in_item.port <= i_s_tdata[PORT_W-1:0];
            r_in_item.data <= i_s_tdata[PORT_W +: BYTE_W];
        end
    end

    cwt_core #(
        .CRTC_REG_COUNT (CRTC_REG_COUNT)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_item   (r_in_item),
        .o_result (core_res)
    );

    // Hold the result until its transfer completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_res <= core_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = M_TDATA_W'({r_out_res.nmi_request, r_out_res.read_data});
    assign o_m_tuser  = r_out_res.claimed;

endmodule
